FILE: hdl/lppm_pkg.sv
// Shared types, codes and pattern tables for the LED pattern priority manager.
`default_nettype none

package lppm_pkg;

    // Request commands
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Cell operations
    localparam logic [1:0] OP_NOP = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;
    localparam logic [1:0] OP_POP = 2'd3;

    localparam logic [2:0] PAT_LINE   = 3'd6;
    localparam logic [3:0] RANGE_NONE = 4'hF;
    localparam int unsigned MAX_RANGES = 16;
    localparam int unsigned BOUND_COLS = 8;

    localparam logic [3:0] PAT_COUNT [8] = '{
        4'd0, 4'd3, 4'd3, 4'd3, 4'd5, 4'd7, 4'd0, 4'd0
    };

    localparam logic [31:0] PAT_BOUNDS [8][BOUND_COLS] = '{
        '{32'd0, 32'd0,    32'd0,    32'd0,    32'd0,    32'd0,    32'd0,    32'd0},
        '{32'd0, 32'd500,  32'd1000, 32'd0,    32'd0,    32'd0,    32'd0,    32'd0},
        '{32'd0, 32'd100,  32'd200,  32'd0,    32'd0,    32'd0,    32'd0,    32'd0},
        '{32'd0, 32'd1000, 32'd1500, 32'd0,    32'd0,    32'd0,    32'd0,    32'd0},
        '{32'd0, 32'd1000, 32'd1250, 32'd1500, 32'd1750, 32'd0,    32'd0,    32'd0},
        '{32'd0, 32'd1000, 32'd1250, 32'd1500, 32'd1750, 32'd2000, 32'd2250, 32'd0},
        '{32'd0, 32'd0,    32'd0,    32'd0,    32'd0,    32'd0,    32'd0,    32'd0},
        '{32'd0, 32'd0,    32'd0,    32'd0,    32'd0,    32'd0,    32'd0,    32'd0}
    };

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         request_id;
        logic signed [7:0]  priority_req;
        logic [2:0]         pattern;
        logic [31:0]        expiry_time;
        logic [31:0]        tick_time;
    } req_t;

    typedef struct packed {
        logic       led_on;
        logic       forced_off_write;
        logic       new_value_write;
        logic [1:0] status;
    } rsp_t;

    // One table slot
    typedef struct packed {
        logic               valid;
        logic [7:0]         id;
        logic signed [7:0]  prio;
        logic [2:0]         pat;
        logic [31:0]        expiry;
    } entry_t;

    // Broadcast to every cell; the operation travels on its own port
    typedef struct packed {
        logic [7:0]         id;
        logic signed [7:0]  prio;
        logic [2:0]         pat;
        logic [31:0]        expiry;
    } cell_ctrl_t;

    typedef struct packed {
        logic       found;
        logic [3:0] idx;
    } range_t;

    // Range holding elapsed time t; found is low once past the last boundary.
    function automatic range_t find_range(input logic [2:0] pat, input logic [31:0] t);
        range_t      r;
        int unsigned cnt;
        r.found = 1'b0;
        r.idx   = RANGE_NONE;
        cnt = int'(PAT_COUNT[pat]);
        if (cnt > MAX_RANGES)
        begin
            cnt = MAX_RANGES;
        end
        for (int i = 0; i < BOUND_COLS - 1; i++)
        begin
            if (!r.found && (i + 1 < cnt) && (t >= PAT_BOUNDS[pat][i])
                && (t < PAT_BOUNDS[pat][i + 1]))
            begin
                r.found = 1'b1;
                r.idx   = 4'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/led_pattern_priority_manager.sv
// Top level: LED request table as a chain of cells plus the pattern sequencer.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  req     | in        | req_valid / req_stall | req_t: command and fields
//  rsp     | out       | rsp_valid / rsp_stall | rsp_t: LED and status
//
// Add and remove: accepted in S_IDLE, then in S_EXEC every cell compares
// and shifts in parallel. A tick runs S_POP, which pops expired heads with
// one left shift of the whole chain each, then S_ELAP and S_RANGE.
// A result waits in the output register; while it is stalled the sequencer
// holds in its last step. Reset empties the table and forces a pattern
// restart on the first tick. Only one request is in work at a time.
`default_nettype none

module led_pattern_priority_manager
    import lppm_pkg::*;
#(
    parameter int MAX_REQUESTS = 8
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_ELAP  = 3'd3;
    localparam logic [2:0] S_RANGE = 3'd4;

    logic [2:0]  state_reg,       state_next;
    req_t        req_reg,         req_next;
    logic        led_reg,         led_next;
    logic [31:0] start_time_reg,  start_time_next;
    logic        start_valid_reg, start_valid_next;
    logic [3:0]  last_range_reg,  last_range_next;
    logic [31:0] elapsed_reg,     elapsed_next;
    logic        forced_reg,      forced_next;
    logic        rsp_valid_reg,   rsp_valid_next;
    rsp_t        rsp_reg,         rsp_next;

    cell_ctrl_t  ctrl;
    logic [1:0]  cell_op;
    entry_t      entries  [MAX_REQUESTS];
    logic        pass_chain [MAX_REQUESTS + 1];
    logic        hit_chain  [MAX_REQUESTS + 1];

    entry_t      head;
    logic        out_free;
    logic        head_expired;
    range_t      rng;
    logic        nv;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // compare key for every cell comes straight from the held request
    assign ctrl = '{id: req_reg.request_id, prio: req_reg.priority_req,
                    pat: req_reg.pattern, expiry: req_reg.expiry_time};

    assign pass_chain[0] = 1'b1;
    assign hit_chain[0]  = 1'b0;

    // The table: cell 0 is the head, highest priority first.
    for (genvar g = 0; g < MAX_REQUESTS; g++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        if (g == 0)
        begin : g_first
            assign left_e = '0;
        end
        else
        begin : g_mid
            assign left_e = entries[g - 1];
        end
        if (g == MAX_REQUESTS - 1)
        begin : g_last
            assign right_e = '0;
        end
        else
        begin : g_inner
            assign right_e = entries[g + 1];
        end

        lppm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .op       (cell_op),
            .ctrl     (ctrl),
            .left     (left_e),
            .right    (right_e),
            .pass_in  (pass_chain[g]),
            .hit_in   (hit_chain[g]),
            .entry    (entries[g]),
            .pass_out (pass_chain[g + 1]),
            .hit_out  (hit_chain[g + 1])
        );
    end

    assign head         = entries[0];
    assign head_expired = head.valid && (head.expiry != 32'd0)
                          && (req_reg.tick_time > head.expiry);
    assign rng          = find_range(head.pat, elapsed_reg);

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        led_next         = led_reg;
        start_time_next  = start_time_reg;
        start_valid_next = start_valid_reg;
        last_range_next  = last_range_reg;
        elapsed_next     = elapsed_reg;
        forced_next      = forced_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        rsp_next         = rsp_reg;
        nv               = led_reg;
        cell_op          = OP_NOP;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = (req.command == CMD_TICK) ? S_POP : S_EXEC;
                end
            end

            // add, remove, or an unknown command
            S_EXEC:
            begin
                if (out_free)
                begin
                    rsp_next = '{led_on: led_reg, forced_off_write: 1'b0,
                                 new_value_write: 1'b0, status: ST_OK};
                    if (req_reg.command == CMD_ADD)
                    begin
                        // hit chain doubles as the duplicate check
                        if (hit_chain[MAX_REQUESTS])
                        begin
                            rsp_next.status = ST_DUPLICATE;
                        end
                        else if (entries[MAX_REQUESTS - 1].valid)
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            cell_op = OP_ADD;
                            if (!pass_chain[1])
                            begin
                                start_valid_next = 1'b0;
                                last_range_next  = RANGE_NONE;
                            end
                        end
                    end
                    else if (req_reg.command == CMD_REMOVE)
                    begin
                        if (!hit_chain[MAX_REQUESTS])
                        begin
                            rsp_next.status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            cell_op = OP_DEL;
                            if (hit_chain[1])
                            begin
                                start_valid_next = 1'b0;
                                last_range_next  = RANGE_NONE;
                            end
                        end
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            // drop expired heads, one per cycle
            S_POP:
            begin
                if (head_expired)
                begin
                    cell_op          = OP_POP;
                    start_valid_next = 1'b0;
                    last_range_next  = RANGE_NONE;
                end
                else
                begin
                    state_next = S_ELAP;
                end
            end

            // forced restart and elapsed pattern time
            S_ELAP:
            begin
                forced_next = !start_valid_reg;
                if (!start_valid_reg)
                begin
                    start_valid_next = 1'b1;
                    start_time_next  = req_reg.tick_time;
                    led_next         = 1'b0;
                    elapsed_next     = 32'd0;
                end
                else
                begin
                    elapsed_next = req_reg.tick_time - start_time_reg;
                end
                state_next = S_RANGE;
            end

            S_RANGE:
            begin
                if (out_free)
                begin
                    if (!head.valid)
                    begin
                        nv              = 1'b0;
                        start_time_next = req_reg.tick_time;
                    end
                    else if (head.pat == PAT_LINE)
                    begin
                        nv = 1'b1;
                    end
                    else if (PAT_COUNT[head.pat] == 4'd0)
                    begin
                        nv = 1'b0;
                    end
                    else if (!rng.found)
                    begin
                        // past the last boundary: restart switched on
                        nv              = 1'b1;
                        start_time_next = req_reg.tick_time;
                        last_range_next = 4'd0;
                    end
                    else
                    begin
                        if (rng.idx != last_range_reg)
                        begin
                            nv = !led_reg;
                        end
                        last_range_next = rng.idx;
                    end
                    led_next       = nv;
                    rsp_next       = '{led_on: nv, forced_off_write: forced_reg,
                                       new_value_write: (nv != led_reg), status: ST_OK};
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            led_reg         <= 1'b0;
            start_time_reg  <= 32'd0;
            start_valid_reg <= 1'b0;
            last_range_reg  <= RANGE_NONE;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            led_reg         <= led_next;
            start_time_reg  <= start_time_next;
            start_valid_reg <= start_valid_next;
            last_range_reg  <= last_range_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        elapsed_reg <= elapsed_next;
        forced_reg  <= forced_next;
        rsp_reg     <= rsp_next;
    end

endmodule

`default_nettype wire

FILE: hdl/lppm_cell.sv
// One slot of the sorted request table; shifts to either neighbor.
`default_nettype none

module lppm_cell
    import lppm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [1:0] op,
    input  wire cell_ctrl_t ctrl,
    input  wire entry_t     left,
    input  wire entry_t     right,
    input  wire logic       pass_in,
    input  wire logic       hit_in,
    output entry_t          entry,
    output logic            pass_out,
    output logic            hit_out
);

    logic       valid_reg;
    logic       valid_next;
    entry_t     data_reg;
    entry_t     data_next;
    logic       pass_here;
    logic       hit_here;

    assign entry     = '{valid: valid_reg, id: data_reg.id, prio: data_reg.prio,
                         pat: data_reg.pat, expiry: data_reg.expiry};
    // new request sorts behind this one
    assign pass_here = valid_reg && ($signed(ctrl.prio) < $signed(data_reg.prio));
    assign hit_here  = valid_reg && (data_reg.id == ctrl.id);
    assign pass_out  = pass_in && pass_here;
    assign hit_out   = hit_in || hit_here;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = entry;
        unique case (op)
            OP_ADD:
            begin
                if (!pass_out)
                begin
                    if (pass_in)
                    begin
                        valid_next = 1'b1;
                        data_next  = '{valid: 1'b1, id: ctrl.id, prio: ctrl.prio,
                                       pat: ctrl.pat, expiry: ctrl.expiry};
                    end
                    else
                    begin
                        valid_next = left.valid;
                        data_next  = left;
                    end
                end
            end
            OP_DEL:
            begin
                if (hit_out)
                begin
                    valid_next = right.valid;
                    data_next  = right;
                end
            end
            OP_POP:
            begin
                valid_next = right.valid;
                data_next  = right;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire
